// ----- sv/rpwd_pkg.sv -----
// Shared types, constants and helper functions of the RGB PWM dimmer with strobe.
package rpwd_pkg;

  localparam logic [7:0] STROBE_BASE = 8'd3;
  localparam logic [7:0] STROBE_SPAN = 8'd127;
  localparam int unsigned SCALE_SHIFT = 8;

  typedef enum logic [1:0] {
    OP_SET_STRIP   = 2'd0,
    OP_SET_LAMP    = 2'd1,
    OP_PWM_TICK    = 2'd2,
    OP_STROBE_TICK = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] master_level;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] rate;
  } in_item_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic lamp_on;
    logic pwm_running;
  } out_item_t;

  function automatic logic [7:0] period_of(input logic [7:0] rate);
    return STROBE_BASE + STROBE_SPAN - {1'b0, rate[7:1]};
  endfunction

  function automatic logic [7:0] scale(input logic [7:0] master, input logic [7:0] level);
    logic [15:0] prod;
    prod = master * level;
    return prod[SCALE_SHIFT +: 8];
  endfunction

endpackage

// ----- sv/rpwd_in_if.sv -----
// Input channel interface carrying one command transaction.
interface rpwd_in_if import rpwd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rpwd_out_if.sv -----
// Result channel interface carrying the output drive state.
interface rpwd_out_if import rpwd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rpwd_core.sv -----
// State registers and combinational next-state logic of the dimmer and both strobes.
module rpwd_core import rpwd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result_nxt
);

  logic [7:0] red_scaled_r, red_scaled_nxt;
  logic [7:0] green_scaled_r, green_scaled_nxt;
  logic [7:0] blue_scaled_r, blue_scaled_nxt;
  logic [7:0] pwm_phase_r, pwm_phase_nxt;
  logic       pwm_enable_r, pwm_enable_nxt;
  logic [2:0] colour_drive_r, colour_drive_nxt;
  logic       lamp_drive_r, lamp_drive_nxt;
  logic [7:0] strip_period_r, strip_period_nxt;
  logic [7:0] strip_countdown_r, strip_countdown_nxt;
  logic [7:0] lamp_period_r, lamp_period_nxt;
  logic [7:0] lamp_countdown_r, lamp_countdown_nxt;

  logic [7:0] new_period;
  logic [7:0] lamp_dec;
  logic [7:0] strip_dec;

  assign new_period = period_of(item.rate);
  assign lamp_dec   = lamp_countdown_r - 8'd1;
  assign strip_dec  = strip_countdown_r - 8'd1;

  always_comb begin
    red_scaled_nxt      = red_scaled_r;
    green_scaled_nxt    = green_scaled_r;
    blue_scaled_nxt     = blue_scaled_r;
    pwm_phase_nxt       = pwm_phase_r;
    pwm_enable_nxt      = pwm_enable_r;
    colour_drive_nxt    = colour_drive_r;
    lamp_drive_nxt      = lamp_drive_r;
    strip_period_nxt    = strip_period_r;
    strip_countdown_nxt = strip_countdown_r;
    lamp_period_nxt     = lamp_period_r;
    lamp_countdown_nxt  = lamp_countdown_r;
    if (step) begin
      unique case (op_t'(item.operation))
        OP_SET_STRIP: begin
          red_scaled_nxt   = scale(item.master_level, item.red_level);
          green_scaled_nxt = scale(item.master_level, item.green_level);
          blue_scaled_nxt  = scale(item.master_level, item.blue_level);
          if (item.rate == 8'd0) begin
            strip_period_nxt = 8'd0;
            pwm_phase_nxt    = 8'd0;
            pwm_enable_nxt   = 1'b1;
          end else if (strip_period_r != new_period) begin
            if (strip_period_r == 8'd0) begin
              strip_countdown_nxt = 8'd1;
            end
            strip_period_nxt = new_period;
          end
        end
        OP_SET_LAMP: begin
          if (item.rate == 8'd0) begin
            lamp_period_nxt = 8'd0;
            lamp_drive_nxt  = 1'b0;
          end else if (lamp_period_r != new_period) begin
            if (lamp_period_r == 8'd0) begin
              lamp_countdown_nxt = 8'd1;
            end
            lamp_period_nxt = new_period;
          end
        end
        OP_PWM_TICK: begin
          if (pwm_enable_r) begin
            if (pwm_phase_r == 8'd0) begin
              colour_drive_nxt = {blue_scaled_r != 8'd0, green_scaled_r != 8'd0,
                                  red_scaled_r != 8'd0};
            end else begin
              if (pwm_phase_r == red_scaled_r) colour_drive_nxt[0] = 1'b0;
              if (pwm_phase_r == green_scaled_r) colour_drive_nxt[1] = 1'b0;
              if (pwm_phase_r == blue_scaled_r) colour_drive_nxt[2] = 1'b0;
            end
            pwm_phase_nxt = pwm_phase_r + 8'd1;
          end
        end
        default: begin
          if (lamp_period_r != 8'd0) begin
            if (lamp_dec == 8'd0) begin
              lamp_drive_nxt     = 1'b1;
              lamp_countdown_nxt = lamp_period_r;
            end else begin
              lamp_drive_nxt     = 1'b0;
              lamp_countdown_nxt = lamp_dec;
            end
          end
          if (strip_period_r != 8'd0) begin
            if (strip_dec == 8'd0) begin
              strip_countdown_nxt = strip_period_r;
              pwm_phase_nxt       = 8'd0;
              pwm_enable_nxt      = 1'b1;
            end else begin
              strip_countdown_nxt = strip_dec;
              colour_drive_nxt    = 3'b000;
              pwm_enable_nxt      = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_scaled_r      <= 8'd0;
      green_scaled_r    <= 8'd0;
      blue_scaled_r     <= 8'd0;
      pwm_phase_r       <= 8'd0;
      pwm_enable_r      <= 1'b1;
      colour_drive_r    <= 3'b000;
      lamp_drive_r      <= 1'b0;
      strip_period_r    <= 8'd0;
      strip_countdown_r <= 8'd0;
      lamp_period_r     <= 8'd0;
      lamp_countdown_r  <= 8'd0;
    end else begin
      red_scaled_r      <= red_scaled_nxt;
      green_scaled_r    <= green_scaled_nxt;
      blue_scaled_r     <= blue_scaled_nxt;
      pwm_phase_r       <= pwm_phase_nxt;
      pwm_enable_r      <= pwm_enable_nxt;
      colour_drive_r    <= colour_drive_nxt;
      lamp_drive_r      <= lamp_drive_nxt;
      strip_period_r    <= strip_period_nxt;
      strip_countdown_r <= strip_countdown_nxt;
      lamp_period_r     <= lamp_period_nxt;
      lamp_countdown_r  <= lamp_countdown_nxt;
    end
  end

  assign result_nxt.red_on      = colour_drive_nxt[0];
  assign result_nxt.green_on    = colour_drive_nxt[1];
  assign result_nxt.blue_on     = colour_drive_nxt[2];
  assign result_nxt.lamp_on     = lamp_drive_nxt;
  assign result_nxt.pwm_running = pwm_enable_nxt;

endmodule

// ----- sv/rgb_pwm_dimmer_with_strobe.sv -----
// Top level of the RGB PWM dimmer with strip strobe and strobe lamp.
// The input register holds an accepted item until the result register is free.
// Throughput: one transaction per cycle unless stalled; state updates on result load.
// Backpressure on the result side stalls the input register, which stalls the input.
// Reset clears valids and core state: PWM enabled, levels, drives, strobe periods zero.
module rgb_pwm_dimmer_with_strobe import rpwd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rpwd_in_if.sink   in_ch,
  rpwd_out_if.source out_ch
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result_nxt;
  logic      in_take;
  logic      out_load;

  assign out_load    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_ch.data;
    end
    if (out_load) begin
      out_item_r <= result_nxt;
    end
  end

  rpwd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (out_load),
    .item       (s1_item_r),
    .result_nxt (result_nxt)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule
